// ===== sv/bls_pkg.sv =====
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types and constants of the brake light sequencer.
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int unsigned CfgW = 16;

  // requested lamp levels
  localparam logic [1:0] LVL_OFF   = 2'd0;
  localparam logic [1:0] LVL_ON    = 2'd1;
  localparam logic [1:0] LVL_FAULT = 2'd2;
  localparam logic [1:0] LVL_RSVD  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_QUIET_TIME  = 2'd0;
  localparam logic [1:0] CFG_FLASH_FIRST = 2'd1;
  localparam logic [1:0] CFG_FLASH_STEP  = 2'd2;
  localparam logic [1:0] CFG_FAULT_HALF  = 2'd3;

  // configuration reset values in ms
  localparam logic [CfgW-1:0] QUIET_TIME_RST  = 16'd4000;
  localparam logic [CfgW-1:0] FLASH_FIRST_RST = 16'd200;
  localparam logic [CfgW-1:0] FLASH_STEP_RST  = 16'd100;
  localparam logic [CfgW-1:0] FAULT_HALF_RST  = 16'd400;

  typedef struct packed {
    logic [CfgW-1:0] quiet_time_ms;
    logic [CfgW-1:0] flash_first_ms;
    logic [CfgW-1:0] flash_step_ms;
    logic [CfgW-1:0] fault_half_ms;
  } cfg_t;

  typedef struct packed {
    logic left;
    logic right;
  } lamps_t;

endpackage

// ===== sv/bls_core.sv =====
// ----------------------------------------------------------------------------
// bls_core
// Level, phase and timer state; one tick or request updated per accepted beat.
// ----------------------------------------------------------------------------
module bls_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic              op,
  input  logic [1:0]        level,
  input  bls_pkg::cfg_t     cfg,
  output bls_pkg::lamps_t   lamps_nxt
);

  typedef enum logic [2:0] {
    PH_STEADY     = 3'd0,
    PH_FLASH_BOTH = 3'd1,
    PH_FLASH_R1   = 3'd2,
    PH_FLASH_L1   = 3'd3,
    PH_FLASH_R2   = 3'd4,
    PH_FLASH_L2   = 3'd5,
    PH_FAULT_R    = 3'd6,
    PH_FAULT_L    = 3'd7
  } phase_t;

  logic [1:0]               held_level_r, held_level_nxt;
  phase_t                   phase_r, phase_nxt;
  logic [bls_pkg::CfgW-1:0] phase_count_r, phase_count_nxt;
  logic [bls_pkg::CfgW-1:0] quiet_count_r, quiet_count_nxt;

  always_comb begin
    held_level_nxt  = held_level_r;
    phase_nxt       = phase_r;
    phase_count_nxt = phase_count_r;
    quiet_count_nxt = quiet_count_r;
    if (op) begin
      // reserved level and repeats of the held level change nothing
      if (level != bls_pkg::LVL_RSVD && level != held_level_r) begin
        held_level_nxt  = level;
        phase_count_nxt = '0;
        if (level == bls_pkg::LVL_OFF) begin
          phase_nxt       = PH_STEADY;
          quiet_count_nxt = cfg.quiet_time_ms;
        end else if (level == bls_pkg::LVL_ON) begin
          if (quiet_count_r == '0) begin
            phase_nxt       = PH_FLASH_BOTH;
            phase_count_nxt = cfg.flash_first_ms;
          end else begin
            phase_nxt = PH_STEADY;
          end
        end else begin
          phase_nxt       = PH_FAULT_R;
          phase_count_nxt = cfg.fault_half_ms;
        end
      end
    end else begin
      if (quiet_count_r != '0) begin
        quiet_count_nxt = quiet_count_r - 1'b1;
      end
      if (phase_r != PH_STEADY) begin
        // a load of zero behaves like one and ends at the next tick
        if (phase_count_r > 16'd1) begin
          phase_count_nxt = phase_count_r - 1'b1;
        end else begin
          unique case (phase_r)
            PH_FAULT_R: begin
              phase_nxt       = PH_FAULT_L;
              phase_count_nxt = cfg.fault_half_ms;
            end
            PH_FAULT_L: begin
              phase_nxt       = PH_FAULT_R;
              phase_count_nxt = cfg.fault_half_ms;
            end
            PH_FLASH_L2: begin
              phase_nxt       = PH_STEADY;
              phase_count_nxt = '0;
            end
            PH_FLASH_BOTH: begin
              phase_nxt       = PH_FLASH_R1;
              phase_count_nxt = cfg.flash_step_ms;
            end
            PH_FLASH_R1: begin
              phase_nxt       = PH_FLASH_L1;
              phase_count_nxt = cfg.flash_step_ms;
            end
            PH_FLASH_L1: begin
              phase_nxt       = PH_FLASH_R2;
              phase_count_nxt = cfg.flash_step_ms;
            end
            PH_FLASH_R2: begin
              phase_nxt       = PH_FLASH_L2;
              phase_count_nxt = cfg.flash_step_ms;
            end
            default: begin
              phase_nxt = phase_r;
            end
          endcase
        end
      end
    end
  end

  // lamps as they stand after this beat
  always_comb begin
    unique case (phase_nxt)
      PH_STEADY: begin
        lamps_nxt.left  = (held_level_nxt == bls_pkg::LVL_ON);
        lamps_nxt.right = (held_level_nxt == bls_pkg::LVL_ON);
      end
      PH_FLASH_BOTH: begin
        lamps_nxt.left  = 1'b1;
        lamps_nxt.right = 1'b1;
      end
      PH_FLASH_R1, PH_FLASH_R2, PH_FAULT_R: begin
        lamps_nxt.left  = 1'b0;
        lamps_nxt.right = 1'b1;
      end
      default: begin
        lamps_nxt.left  = 1'b1;
        lamps_nxt.right = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_level_r  <= bls_pkg::LVL_OFF;
      phase_r       <= PH_STEADY;
      phase_count_r <= '0;
      quiet_count_r <= '0;
    end else if (fire) begin
      held_level_r  <= held_level_nxt;
      phase_r       <= phase_nxt;
      phase_count_r <= phase_count_nxt;
      quiet_count_r <= quiet_count_nxt;
    end
  end

  a_steady_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_STEADY |-> phase_count_r == '0)
    else $error("steady phase with a running phase count");

  a_off_is_steady: assert property (@(posedge clk) disable iff (!rst_n)
    held_level_r == bls_pkg::LVL_OFF |-> phase_r == PH_STEADY)
    else $error("off level outside the steady phase");

  a_fault_alternates: assert property (@(posedge clk) disable iff (!rst_n)
    held_level_r == bls_pkg::LVL_FAULT |-> (phase_r == PH_FAULT_R || phase_r == PH_FAULT_L))
    else $error("fault level outside the fault phases");

endmodule

// ===== sv/brake_light_sequencer.sv =====
// ----------------------------------------------------------------------------
// brake_light_sequencer
// Brake lamp sequencer: off, on with optional flash, and fault alternation.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------
//  in_      | in_valid/in_ready  | in_op, in_level
//  out_     | out_valid/out_ready| out_left_lamp, out_right_lamp
//  cfg_     | cfg_we             | cfg_index, cfg_wdata
//
//  one beat per cycle while in_ready is high; the lamps for a beat are registered before they appear
//  next state and lamps are computed combinationally at accept, lamps land in a two-entry output queue
//  in_ready drops only when both queue entries are full
//  reset: level off, steady phase, quiet timer run out, registers at defaults
// ----------------------------------------------------------------------------
module brake_light_sequencer (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_op,
  input  logic [1:0]               in_level,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_left_lamp,
  output logic                     out_right_lamp,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [bls_pkg::CfgW-1:0] cfg_wdata
);

  bls_pkg::cfg_t   cfg_r;
  bls_pkg::lamps_t lamps_nxt;
  bls_pkg::lamps_t head_r;
  bls_pkg::lamps_t skid_r;
  logic            head_valid_r;
  logic            skid_valid_r;
  logic            accept;
  logic            pop;

  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;
  assign pop      = head_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.quiet_time_ms  <= bls_pkg::QUIET_TIME_RST;
      cfg_r.flash_first_ms <= bls_pkg::FLASH_FIRST_RST;
      cfg_r.flash_step_ms  <= bls_pkg::FLASH_STEP_RST;
      cfg_r.fault_half_ms  <= bls_pkg::FAULT_HALF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bls_pkg::CFG_QUIET_TIME:  cfg_r.quiet_time_ms  <= cfg_wdata;
        bls_pkg::CFG_FLASH_FIRST: cfg_r.flash_first_ms <= cfg_wdata;
        bls_pkg::CFG_FLASH_STEP:  cfg_r.flash_step_ms  <= cfg_wdata;
        bls_pkg::CFG_FAULT_HALF:  cfg_r.fault_half_ms  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bls_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (accept),
    .op        (in_op),
    .level     (in_level),
    .cfg       (cfg_r),
    .lamps_nxt (lamps_nxt)
  );

  // two-entry output queue: head drives the port, skid catches a stalled beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        head_r       <= skid_r;
        skid_valid_r <= 1'b0;
      end else if (accept) begin
        head_r <= lamps_nxt;
      end else begin
        head_valid_r <= 1'b0;
      end
    end else if (accept) begin
      if (!head_valid_r) begin
        head_r       <= lamps_nxt;
        head_valid_r <= 1'b1;
      end else begin
        skid_r       <= lamps_nxt;
        skid_valid_r <= 1'b1;
      end
    end
  end

  assign out_valid      = head_valid_r;
  assign out_left_lamp  = head_r.left;
  assign out_right_lamp = head_r.right;

  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> head_valid_r)
    else $error("skid entry filled with an empty head");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    accept && head_valid_r && !out_ready |=> skid_valid_r)
    else $error("stalled beat not caught by the skid entry");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && out_ready |=> head_valid_r && !skid_valid_r && head_r == $past(skid_r))
    else $error("skid entry lost on a drained head");

endmodule
